// ----- hw/rtl/gf64cm_pkg.sv -----
// Shared constants, types and GF(64) arithmetic for the coset minimal polynomial block.
// The field is built from x^6 + x + 1. This package has no dependencies.
package gf64cm_pkg;

	localparam int Deg = 6;
	localparam int NumCoef = Deg + 1;
	localparam int ExpW = 6;
	localparam int CountW = 3;
	localparam int PolyW = NumCoef;

	localparam logic [ExpW-1:0] ExpOrder = 6'd63;
	localparam logic [ExpW-1:0] FieldPolyLow = 6'h03;

	localparam logic [ExpW-1:0] AlphaPow [64] = '{
		6'h01, 6'h02, 6'h04, 6'h08, 6'h10, 6'h20, 6'h03, 6'h06,
		6'h0C, 6'h18, 6'h30, 6'h23, 6'h05, 6'h0A, 6'h14, 6'h28,
		6'h13, 6'h26, 6'h0F, 6'h1E, 6'h3C, 6'h3B, 6'h35, 6'h29,
		6'h11, 6'h22, 6'h07, 6'h0E, 6'h1C, 6'h38, 6'h33, 6'h25,
		6'h09, 6'h12, 6'h24, 6'h0B, 6'h16, 6'h2C, 6'h1B, 6'h36,
		6'h2F, 6'h1D, 6'h3A, 6'h37, 6'h2D, 6'h19, 6'h32, 6'h27,
		6'h0D, 6'h1A, 6'h34, 6'h2B, 6'h15, 6'h2A, 6'h17, 6'h2E,
		6'h1F, 6'h3E, 6'h3F, 6'h3D, 6'h39, 6'h31, 6'h21, 6'h01
	};

	typedef struct packed {
		logic init;
		logic step;
	} cell_ctrl_t;

	function automatic logic [ExpW-1:0] gf_mul(input logic [ExpW-1:0] a,
			input logic [ExpW-1:0] b);
		logic [ExpW-1:0] acc;
		logic [ExpW-1:0] sh;
		acc = '0;
		sh = a;
		for (int i = 0; i < Deg; i++) begin
			if (b[i]) begin
				acc = acc ^ sh;
			end
			sh = {sh[ExpW-2:0], 1'b0} ^ (sh[ExpW-1] ? FieldPolyLow : '0);
		end
		return acc;
	endfunction

	function automatic logic [ExpW-1:0] rotl1(input logic [ExpW-1:0] x);
		return {x[ExpW-2:0], x[ExpW-1]};
	endfunction

endpackage

// ----- hw/rtl/gf64_coset_minimal_polynomial.sv -----
// Top level of the GF(64) cyclotomic coset and minimal polynomial block.
// Holds the sequencer and a chain of seven coefficient cells; depends on gf64cm_pkg
// and gf64cm_cell.
//
// Input channel: exponent with exp_valid and exp_stall. A transfer takes place on a
// rising edge with exp_valid high and exp_stall low. An exponent of 63 is treated as 0.
// Output channel: member, coset_size, min_poly and is_last with res_valid and res_stall.
// One result leaves per coset member in doubling order from the exponent; the last one
// has is_last set and carries the minimal polynomial, and min_poly is zero on the others.
//
// The block works on one exponent at a time. After the input transfer the cell chain
// takes one step per coset member, each step one root multiplied into all seven
// coefficients at once, and then the results are sent one per cycle while the
// receiver keeps up.
// exp_stall stays high from the transfer until the last result is loaded into the
// output register, so the next exponent can be taken while that result still waits.
// A stalling receiver holds the output register and pauses the result sequence.
// Reset clears the sequencer and the output valid; the block then waits for an input.
module gf64_coset_minimal_polynomial (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              exp_valid,
	output logic                              exp_stall,
	input  logic [gf64cm_pkg::ExpW-1:0]       exponent,
	output logic                              res_valid,
	input  logic                              res_stall,
	output logic [gf64cm_pkg::ExpW-1:0]       member,
	output logic [gf64cm_pkg::CountW-1:0]     coset_size,
	output logic [gf64cm_pkg::PolyW-1:0]      min_poly,
	output logic                              is_last
);

	typedef enum logic [1:0] {
		StIdle,
		StRun,
		StEmit
	} state_t;

	state_t                                state_q;
	logic [gf64cm_pkg::ExpW-1:0]           start_q;
	logic [gf64cm_pkg::ExpW-1:0]           cur_q;
	logic [gf64cm_pkg::CountW-1:0]         count_q;
	logic [gf64cm_pkg::CountW-1:0]         emit_cnt_q;
	logic                                  res_valid_q;
	logic [gf64cm_pkg::ExpW-1:0]           member_q;
	logic [gf64cm_pkg::CountW-1:0]         size_q;
	logic [gf64cm_pkg::PolyW-1:0]          min_poly_q;
	logic                                  is_last_q;

	logic [gf64cm_pkg::ExpW-1:0]           start;
	logic [gf64cm_pkg::ExpW-1:0]           cur_next;
	logic [gf64cm_pkg::CountW-1:0]         count_inc;
	logic                                  emit_last;
	logic                                  load_res;
	logic [gf64cm_pkg::ExpW-1:0]           root;
	logic [gf64cm_pkg::PolyW-1:0]          minp;
	gf64cm_pkg::cell_ctrl_t                cell_ctrl;
	logic [gf64cm_pkg::ExpW-1:0]           coef [gf64cm_pkg::NumCoef];

	assign start = (exponent == gf64cm_pkg::ExpOrder) ? '0 : exponent;
	assign cur_next = gf64cm_pkg::rotl1(cur_q);
	assign count_inc = count_q + 3'd1;
	assign emit_last = (gf64cm_pkg::CountW'(emit_cnt_q + 3'd1) == count_q);
	assign load_res = (state_q == StEmit) && (!res_valid_q || !res_stall);
	assign root = gf64cm_pkg::AlphaPow[cur_q];

	assign exp_stall = (state_q != StIdle);
	assign cell_ctrl.init = (state_q == StIdle) && exp_valid;
	assign cell_ctrl.step = (state_q == StRun);

	for (genvar i = 0; i < gf64cm_pkg::NumCoef; i++) begin : g_cell
		logic [gf64cm_pkg::ExpW-1:0] prev;
		if (i == 0) begin : g_first
			assign prev = '0;
		end else begin : g_rest
			assign prev = coef[i-1];
		end
		gf64cm_cell u_cell (
			.clk       (clk),
			.ctrl      (cell_ctrl),
			.init_coef ((i == 0) ? gf64cm_pkg::ExpW'(1) : gf64cm_pkg::ExpW'(0)),
			.root      (root),
			.prev_coef (prev),
			.coef      (coef[i])
		);
		assign minp[i] = coef[i][0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= StIdle;
			start_q     <= '0;
			cur_q       <= '0;
			count_q     <= '0;
			emit_cnt_q  <= '0;
			res_valid_q <= 1'b0;
			member_q    <= '0;
			size_q      <= '0;
			min_poly_q  <= '0;
			is_last_q   <= 1'b0;
		end else begin
			if (res_valid_q && !res_stall && !load_res) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				StIdle: begin
					if (exp_valid) begin
						start_q <= start;
						cur_q   <= start;
						count_q <= '0;
						state_q <= StRun;
					end
				end
				StRun: begin
					count_q <= count_inc;
					if (cur_next == start_q ||
							count_inc == gf64cm_pkg::CountW'(gf64cm_pkg::Deg)) begin
						cur_q      <= start_q;
						emit_cnt_q <= '0;
						state_q    <= StEmit;
					end else begin
						cur_q <= cur_next;
					end
				end
				StEmit: begin
					if (load_res) begin
						res_valid_q <= 1'b1;
						member_q    <= cur_q;
						size_q      <= count_q;
						is_last_q   <= emit_last;
						min_poly_q  <= emit_last ? minp : '0;
						cur_q       <= cur_next;
						emit_cnt_q  <= gf64cm_pkg::CountW'(emit_cnt_q + 3'd1);
						if (emit_last) begin
							state_q <= StIdle;
						end
					end
				end
				default: begin
					state_q <= StIdle;
				end
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign member = member_q;
	assign coset_size = size_q;
	assign min_poly = min_poly_q;
	assign is_last = is_last_q;

	a_poly_zero_unless_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !is_last_q |-> min_poly_q == '0)
		else $error("min_poly is not zero on a result that is not the last");

	a_poly_monic: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && is_last_q |-> (min_poly_q >> size_q) == 7'd1)
		else $error("minimal polynomial degree differs from the coset size");

	a_size_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> size_q != '0 && size_q <= gf64cm_pkg::CountW'(gf64cm_pkg::Deg))
		else $error("coset size out of range");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == StEmit |-> count_q != '0 && emit_cnt_q < count_q)
		else $error("result index runs past the coset size");

endmodule

// ----- hw/rtl/gf64cm_cell.sv -----
// One coefficient cell of the polynomial product chain.
// Multiplies its coefficient by the current root and adds the lower neighbor's coefficient.
// Depends on gf64cm_pkg.
module gf64cm_cell (
	input  logic                          clk,
	input  gf64cm_pkg::cell_ctrl_t        ctrl,
	input  logic [gf64cm_pkg::ExpW-1:0]   init_coef,
	input  logic [gf64cm_pkg::ExpW-1:0]   root,
	input  logic [gf64cm_pkg::ExpW-1:0]   prev_coef,
	output logic [gf64cm_pkg::ExpW-1:0]   coef
);

	logic [gf64cm_pkg::ExpW-1:0] coef_q;

	always_ff @(posedge clk) begin
		if (ctrl.init) begin
			coef_q <= init_coef;
		end else if (ctrl.step) begin
			coef_q <= gf64cm_pkg::gf_mul(coef_q, root) ^ prev_coef;
		end
	end

	assign coef = coef_q;

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for gf64_coset_minimal_polynomial: queued exponents are driven
// with random idling and every coset member result is checked against a local prediction.
// Depends on gf64cm_pkg for the port widths and on the block itself.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RandomItems = 130;
	localparam int QuietLimit = 4000;
	localparam int DrainCycles = 30;

	typedef struct packed {
		logic [gf64cm_pkg::ExpW-1:0] member;
		logic [gf64cm_pkg::CountW-1:0] size;
		logic [gf64cm_pkg::PolyW-1:0] poly;
		logic last;
	} coset_member_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic exp_valid = 1'b0;
	logic exp_stall;
	logic [gf64cm_pkg::ExpW-1:0] exponent = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	logic [gf64cm_pkg::ExpW-1:0] member;
	logic [gf64cm_pkg::CountW-1:0] coset_size;
	logic [gf64cm_pkg::PolyW-1:0] min_poly;
	logic is_last;

	logic [gf64cm_pkg::ExpW-1:0] alpha_exp [63];
	logic [gf64cm_pkg::ExpW-1:0] alpha_log [64];
	logic [gf64cm_pkg::ExpW-1:0] exponents_todo [$];
	coset_member_t members_due [$];
	int total_items = 1;
	int items_sent = 0;
	int members_seen = 0;
	int errors = 0;
	int quiet_cycles = 0;

	always #1 clk = ~clk;

	gf64_coset_minimal_polynomial DUT (
		.clk(clk),
		.arst_n(arst_n),
		.exp_valid(exp_valid),
		.exp_stall(exp_stall),
		.exponent(exponent),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.member(member),
		.coset_size(coset_size),
		.min_poly(min_poly),
		.is_last(is_last)
	);

	function automatic logic [gf64cm_pkg::ExpW-1:0] field_mul(
			input logic [gf64cm_pkg::ExpW-1:0] a,
			input logic [gf64cm_pkg::ExpW-1:0] b);
		if (a == '0 || b == '0) begin
			return '0;
		end
		return alpha_exp[(int'(alpha_log[a]) + int'(alpha_log[b])) % 63];
	endfunction

	function automatic int traffic_phase();
		if (items_sent * 3 < total_items) begin
			return 0;
		end else if (items_sent * 3 < 2 * total_items) begin
			return 1;
		end
		return 2;
	endfunction

	function automatic int sender_idle_pct();
		case (traffic_phase())
			0: begin
				return 38;
			end
			1: begin
				return 70;
			end
			default: begin
				return 0;
			end
		endcase
	endfunction

	function automatic int receiver_idle_pct();
		case (traffic_phase())
			0: begin
				return 70;
			end
			1: begin
				return 38;
			end
			default: begin
				return 0;
			end
		endcase
	endfunction

	// The coset is built by doubling modulo 63, and the product of (x + alpha^c) is
	// multiplied out one root at a time; the binary polynomial is bit 0 of each coefficient.
	task automatic predict_coset(input logic [gf64cm_pkg::ExpW-1:0] e);
		int roots [gf64cm_pkg::Deg];
		int start;
		int cur;
		int n;
		logic [gf64cm_pkg::ExpW-1:0] coef [gf64cm_pkg::NumCoef];
		logic [gf64cm_pkg::ExpW-1:0] nxt [gf64cm_pkg::NumCoef];
		logic [gf64cm_pkg::PolyW-1:0] poly;
		coset_member_t r;
		start = int'(e) % 63;
		cur = start;
		n = 0;
		do begin
			roots[n] = cur;
			n++;
			cur = (cur * 2) % 63;
		end while (cur != start && n < gf64cm_pkg::Deg);
		foreach (coef[i]) begin
			coef[i] = '0;
		end
		coef[0] = 6'd1;
		for (int k = 0; k < n; k++) begin
			for (int i = 0; i < gf64cm_pkg::NumCoef; i++) begin
				nxt[i] = field_mul(coef[i], alpha_exp[roots[k]]);
				if (i > 0) begin
					nxt[i] = nxt[i] ^ coef[i-1];
				end
			end
			coef = nxt;
		end
		for (int i = 0; i < gf64cm_pkg::NumCoef; i++) begin
			poly[i] = coef[i][0];
		end
		for (int k = 0; k < n; k++) begin
			r.member = gf64cm_pkg::ExpW'(roots[k]);
			r.size = gf64cm_pkg::CountW'(n);
			r.last = (k == n - 1);
			r.poly = r.last ? poly : '0;
			members_due.push_back(r);
		end
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			exp_valid <= 1'b0;
		end else if (!(exp_valid && exp_stall)) begin
			if (exp_valid) begin
				predict_coset(exponent);
				items_sent <= items_sent + 1;
			end
			if (exponents_todo.size() > 0 && $urandom_range(99) >= sender_idle_pct()) begin
				exponent <= exponents_todo.pop_front();
				exp_valid <= 1'b1;
			end else begin
				exp_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		coset_member_t want;
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			if (res_valid && !res_stall) begin
				members_seen++;
				if (members_due.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual member %0d", $time,
						member);
					errors++;
				end else begin
					want = members_due.pop_front();
					check_field("member", want.member, member);
					check_field("coset_size", want.size, coset_size);
					check_field("min_poly", want.poly, min_poly);
					check_field("is_last", want.last, is_last);
				end
			end
			res_stall <= ($urandom_range(99) < receiver_idle_pct());
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((exp_valid && !exp_stall) || (res_valid && !res_stall)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (quiet_cycles >= QuietLimit) begin
				$display("%0t: no transfer for %0d cycles", $time, QuietLimit);
				$display("testbench: FAIL");
				$finish;
			end
		end
	end

	initial begin
		logic [gf64cm_pkg::ExpW-1:0] v;
		logic [gf64cm_pkg::ExpW-1:0] directed [$];
		v = 6'd1;
		for (int i = 0; i < 63; i++) begin
			alpha_exp[i] = v;
			alpha_log[v] = gf64cm_pkg::ExpW'(i);
			v = {v[gf64cm_pkg::ExpW-2:0], 1'b0} ^ (v[gf64cm_pkg::ExpW-1] ? 6'h03 : 6'h00);
		end
		alpha_log[0] = '0;
		// Both ends of the range, the out-of-range value that folds to zero, and cosets
		// of every size that occurs: one, two, three and six members.
		directed = '{6'd0, 6'd63, 6'd1, 6'd62, 6'd21, 6'd42, 6'd9, 6'd27, 6'd7, 6'd31,
			6'd32, 6'd63, 6'd0, 6'd5, 6'd11, 6'd13, 6'd15, 6'd23, 6'd45, 6'd54};
		exponents_todo = directed;
		for (int i = 0; i < RandomItems; i++) begin
			exponents_todo.push_back($urandom_range(63));
		end
		total_items = exponents_todo.size();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		while (exponents_todo.size() > 0 || exp_valid) begin
			@(posedge clk);
		end
		while (members_due.size() > 0) begin
			@(posedge clk);
		end
		repeat (DrainCycles) @(posedge clk);
		$display("Sent %0d exponents and checked %0d coset member results, %0d errors.",
			items_sent, members_seen, errors);
		if (errors == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/gf64cm_pkg.sv
hw/rtl/gf64cm_cell.sv
hw/rtl/gf64_coset_minimal_polynomial.sv
test/testbench.sv
